>>> rtl/core/srv_pkg.sv
`default_nettype none
package srv_pkg;

    localparam int DEF_SAMPLE_RATE  = 48000;
    localparam int DEF_MAX_CHANNELS = 2;
    localparam int DEF_SAMPLE_BITS  = 16;

    localparam int LINE_W = 24;
    localparam int COEF_W = 18;
    localparam int PROD_W = LINE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [16:0] UNITY = 17'h10000;

    localparam logic [2:0] REG_GAIN0 = 3'd0;
    localparam logic [2:0] REG_GAIN1 = 3'd1;
    localparam logic [2:0] REG_GAIN2 = 3'd2;
    localparam logic [2:0] REG_GAIN3 = 3'd3;
    localparam logic [2:0] REG_DAMP  = 3'd4;
    localparam logic [2:0] REG_WET   = 3'd5;
    localparam logic [2:0] REG_CHANS = 3'd6;

    typedef struct packed {
        logic en;
        logic load;
    } mac_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/schroeder_reverb.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   channel, sample_in
// out      output     out_valid / out_stall sample_out
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Processed samples pass READ, WAIT, COMB, AP0, AP1, MIX, OUT; bypassed go to OUT.
// The single shared multiply-accumulate unit is used fourteen times per sample.
// After reset the delay memories are cleared, one address per cycle, over addresses
// 0 to MAX_CHANNELS * round(0.0437 * SAMPLE_RATE) - 1, while in_stall stays high.
// A finished result waits in the output register while out_stall is high.
`default_nettype none
module schroeder_reverb
#(
    parameter int SAMPLE_RATE  = srv_pkg::DEF_SAMPLE_RATE,
    parameter int MAX_CHANNELS = srv_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = srv_pkg::DEF_SAMPLE_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic                          channel,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic signed [SAMPLE_BITS-1:0] sample_out,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [16:0]                   cfg_data
);

    localparam int LW = srv_pkg::LINE_W;
    localparam int AW = srv_pkg::ACC_W;

    localparam int CLEN [4] = '{
        (297 * SAMPLE_RATE + 5000) / 10000,
        (371 * SAMPLE_RATE + 5000) / 10000,
        (411 * SAMPLE_RATE + 5000) / 10000,
        (437 * SAMPLE_RATE + 5000) / 10000
    };
    localparam int ALEN [2] = '{
        (50 * SAMPLE_RATE + 5000) / 10000,
        (17 * SAMPLE_RATE + 5000) / 10000
    };
    localparam int MAXD  = MAX_CHANNELS * CLEN[3];
    localparam int CLR_W = $clog2(MAXD);
    localparam int CPW   = $clog2(CLEN[3]);
    localparam int APW   = $clog2(ALEN[0]);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_WAIT  = 4'd3;
    localparam logic [3:0] ST_COMB  = 4'd4;
    localparam logic [3:0] ST_AP0   = 4'd5;
    localparam logic [3:0] ST_AP1   = 4'd6;
    localparam logic [3:0] ST_MIX   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    function automatic logic signed [27:0] rnd16(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v + AW'(32768);
        return t[43:16];
    endfunction

    function automatic logic signed [LW-1:0] sat24(input logic signed [27:0] v);
        logic signed [LW-1:0] r;
        if (v > 28'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -28'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[LW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [27:0] v);
        logic signed [27:0] hi;
        logic signed [27:0] lo;
        logic signed [SAMPLE_BITS-1:0] r;
        hi = 28'((28'sd1 <<< (SAMPLE_BITS - 1)) - 28'sd1);
        lo = -hi - 28'sd1;
        if (v > hi)
        begin
            r = hi[SAMPLE_BITS-1:0];
        end
        else if (v < lo)
        begin
            r = lo[SAMPLE_BITS-1:0];
        end
        else
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    logic [3:0]                    state_reg;
    logic [2:0]                    step_reg;
    logic [1:0]                    k_reg;
    logic                          ch_reg;
    logic                          adv_reg;
    logic signed [LW-1:0]          x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [25:0]            sum_reg;
    logic signed [LW-1:0]          wet_reg;
    logic signed [LW-1:0]          filt_reg;
    logic signed [LW-1:0]          damp_reg [8];
    logic [15:0]                   gain_reg [4];
    logic [16:0]                   dampc_reg;
    logic [16:0]                   mix_reg;
    logic [1:0]                    chans_reg;
    logic [CLR_W-1:0]              clr_cnt_reg;
    logic [CPW-1:0]                cpos_reg [4];
    logic [APW-1:0]                apos_reg [2];
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    logic [16:0]           damp_eff;
    logic [16:0]           mix_eff;
    logic [3:0]            used;
    logic                  ch_active;
    logic                  ch_last;
    logic                  in_req;
    logic                  out_free;
    logic                  clearing;
    logic                  rd_en;
    srv_pkg::mac_ctl_t     mac_ctl;
    logic signed [LW-1:0]  mac_a;
    logic signed [17:0]    mac_b;
    logic signed [AW-1:0]  mac_acc;
    logic signed [LW-1:0]  comb_rd [4];
    logic signed [LW-1:0]  ap_rd [2];
    logic signed [LW-1:0]  rd_k;
    logic signed [LW-1:0]  comb_wdata;
    logic signed [LW-1:0]  ap_wdata;
    logic signed [LW-1:0]  wet_in;
    logic signed [LW-1:0]  ap_buf;
    logic signed [LW-1:0]  half;
    logic signed [24:0]    half_t;
    logic signed [25:0]    wet_t;
    logic signed [27:0]    comb_sum;

    assign damp_eff  = (dampc_reg > srv_pkg::UNITY) ? srv_pkg::UNITY : dampc_reg;
    assign mix_eff   = (mix_reg > srv_pkg::UNITY) ? srv_pkg::UNITY : mix_reg;
    assign in_req    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign clearing  = (state_reg == ST_CLEAR);
    assign rd_en     = (state_reg == ST_READ);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_out = out_data_reg;

    always_comb
    begin
        used = {2'b00, chans_reg};
        if (used == 4'd0)
        begin
            used = 4'd1;
        end
        if (32'(used) > MAX_CHANNELS)
        begin
            used = 4'(MAX_CHANNELS);
        end
    end

    assign ch_active = ({3'b000, channel} < used);
    assign ch_last   = ({3'b000, channel} == used - 4'd1);

    assign rd_k     = comb_rd[k_reg];
    assign comb_sum = 28'(x_reg) + rnd16(mac_acc);
    assign comb_wdata = clearing ? '0 : sat24(comb_sum);

    assign wet_t  = sum_reg + 26'sd2;
    assign wet_in = (state_reg == ST_AP0) ? wet_t[25:2] : wet_reg;
    assign ap_buf = (state_reg == ST_AP0) ? ap_rd[0] : ap_rd[1];
    assign half_t = 25'(ap_buf) + 25'sd1;
    assign half   = half_t[24:1];
    assign ap_wdata = clearing ? '0 : sat24(28'(wet_in) + 28'(half));

    always_comb
    begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        if (state_reg == ST_COMB)
        begin
            case (step_reg)
                3'd0:
                begin
                    mac_ctl = '{en: 1'b1, load: 1'b1};
                    mac_a   = rd_k;
                    mac_b   = signed'({1'b0, srv_pkg::UNITY - damp_eff});
                end
                3'd1:
                begin
                    mac_ctl = '{en: 1'b1, load: 1'b0};
                    mac_a   = damp_reg[{ch_reg, k_reg}];
                    mac_b   = signed'({1'b0, damp_eff});
                end
                3'd4:
                begin
                    mac_ctl = '{en: 1'b1, load: 1'b1};
                    mac_a   = filt_reg;
                    mac_b   = signed'({2'b00, gain_reg[k_reg]});
                end
                default:
                begin
                    mac_ctl = '0;
                end
            endcase
        end
        else if (state_reg == ST_MIX)
        begin
            case (step_reg)
                3'd0:
                begin
                    mac_ctl = '{en: 1'b1, load: 1'b1};
                    mac_a   = x_reg;
                    mac_b   = signed'({1'b0, srv_pkg::UNITY - mix_eff});
                end
                3'd1:
                begin
                    mac_ctl = '{en: 1'b1, load: 1'b0};
                    mac_a   = wet_reg;
                    mac_b   = signed'({1'b0, mix_eff});
                end
                default:
                begin
                    mac_ctl = '0;
                end
            endcase
        end
    end

    srv_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_comb
        localparam int DEPTH = MAX_CHANNELS * CLEN[g];
        localparam int MW    = $clog2(DEPTH);
        logic [31:0]       addr_w;
        logic [MW-1:0]     addr;
        logic [LW-1:0]     rdata;
        logic              we;

        assign addr_w = (ch_reg ? 32'(CLEN[g]) : 32'd0) + 32'(cpos_reg[g]);
        assign we = clearing ? (32'(clr_cnt_reg) < DEPTH)
                             : (state_reg == ST_COMB && step_reg == 3'd6
                                && k_reg == 2'(g));
        assign addr = clearing ? MW'(clr_cnt_reg) : addr_w[MW-1:0];
        assign comb_rd[g] = signed'(rdata);

        srv_dly #(.DEPTH(DEPTH)) u_line
        (
            .clk   (clk),
            .we    (we),
            .waddr (addr),
            .wdata (comb_wdata),
            .re    (rd_en),
            .raddr (addr),
            .rdata (rdata)
        );
    end

    for (genvar g = 0; g < 2; g++)
    begin : g_ap
        localparam int DEPTH = MAX_CHANNELS * ALEN[g];
        localparam int MW    = $clog2(DEPTH);
        logic [31:0]       addr_w;
        logic [MW-1:0]     addr;
        logic [LW-1:0]     rdata;
        logic              we;

        assign addr_w = (ch_reg ? 32'(ALEN[g]) : 32'd0) + 32'(apos_reg[g]);
        assign we = clearing ? (32'(clr_cnt_reg) < DEPTH)
                             : (state_reg == ((g == 0) ? ST_AP0 : ST_AP1));
        assign addr = clearing ? MW'(clr_cnt_reg) : addr_w[MW-1:0];
        assign ap_rd[g] = signed'(rdata);

        srv_dly #(.DEPTH(DEPTH)) u_line
        (
            .clk   (clk),
            .we    (we),
            .waddr (addr),
            .wdata (ap_wdata),
            .re    (rd_en),
            .raddr (addr),
            .rdata (rdata)
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                gain_reg[i] <= '0;
            end
            dampc_reg <= '0;
            mix_reg   <= '0;
            chans_reg <= 2'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srv_pkg::REG_GAIN0: gain_reg[0] <= cfg_data[15:0];
                srv_pkg::REG_GAIN1: gain_reg[1] <= cfg_data[15:0];
                srv_pkg::REG_GAIN2: gain_reg[2] <= cfg_data[15:0];
                srv_pkg::REG_GAIN3: gain_reg[3] <= cfg_data[15:0];
                srv_pkg::REG_DAMP:  dampc_reg   <= cfg_data;
                srv_pkg::REG_WET:   mix_reg     <= cfg_data;
                srv_pkg::REG_CHANS: chans_reg   <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            k_reg         <= '0;
            clr_cnt_reg   <= '0;
            adv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                damp_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                cpos_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                apos_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == MAXD - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_req)
                    begin
                        ch_reg  <= channel;
                        x_reg   <= LW'(sample_in);
                        adv_reg <= ch_last;
                        if (ch_active)
                        begin
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            y_reg     <= sample_in;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_READ:
                begin
                    sum_reg   <= '0;
                    k_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    state_reg <= ST_COMB;
                end
                ST_COMB:
                begin
                    if (step_reg == 3'd3)
                    begin
                        filt_reg <= sat24(rnd16(mac_acc));
                        damp_reg[{ch_reg, k_reg}] <= sat24(rnd16(mac_acc));
                    end
                    if (step_reg == 3'd6)
                    begin
                        step_reg <= '0;
                        sum_reg  <= sum_reg + 26'(rd_k);
                        k_reg    <= k_reg + 2'd1;
                        if (k_reg == 2'd3)
                        begin
                            state_reg <= ST_AP0;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_AP0:
                begin
                    wet_reg   <= sat24(28'(ap_buf) - 28'(wet_in));
                    state_reg <= ST_AP1;
                end
                ST_AP1:
                begin
                    wet_reg   <= sat24(28'(ap_buf) - 28'(wet_in));
                    step_reg  <= '0;
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd3)
                    begin
                        y_reg     <= sat_out(rnd16(mac_acc));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= y_reg;
                        state_reg     <= ST_IDLE;
                        if (adv_reg)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                cpos_reg[i] <= (32'(cpos_reg[i]) == CLEN[i] - 1)
                                               ? '0 : cpos_reg[i] + 1'b1;
                            end
                            for (int i = 0; i < 2; i++)
                            begin
                                apos_reg[i] <= (32'(apos_reg[i]) == ALEN[i] - 1)
                                               ? '0 : apos_reg[i] + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg)
        else $error("result presented during memory clearing");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cpos_reg[0]) < CLEN[0] && 32'(cpos_reg[3]) < CLEN[3]
        && 32'(apos_reg[1]) < ALEN[1])
        else $error("delay position out of range");

    a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_COMB && state_reg != ST_MIX |-> !mac_ctl.en)
        else $error("multiplier used outside filter phases");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished sample not delivered to output register");

endmodule
`default_nettype wire

>>> rtl/core/srv_mac.sv
`default_nettype none
module srv_mac
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire srv_pkg::mac_ctl_t                    ctl,
    input  wire logic signed [srv_pkg::LINE_W-1:0]    a,
    input  wire logic signed [srv_pkg::COEF_W-1:0]    b,
    output      logic signed [srv_pkg::ACC_W-1:0]     acc
);

    logic signed [srv_pkg::PROD_W-1:0] prod_reg;
    logic signed [srv_pkg::ACC_W-1:0]  acc_reg;
    srv_pkg::mac_ctl_t                 ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (ctl_reg.en)
        begin
            if (ctl_reg.load)
            begin
                acc_reg <= srv_pkg::ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + srv_pkg::ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

>>> rtl/core/srv_dly.sv
`default_nettype none
module srv_dly
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [$clog2(DEPTH)-1:0]          waddr,
    input  wire logic [srv_pkg::LINE_W-1:0]        wdata,
    input  wire logic                              re,
    input  wire logic [$clog2(DEPTH)-1:0]          raddr,
    output      logic [srv_pkg::LINE_W-1:0]        rdata
);

    logic [srv_pkg::LINE_W-1:0] mem [DEPTH];
    logic [srv_pkg::LINE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
